### rtl/sgm_pkg.sv
// Shared types, widths and constants of the Sobel gradient magnitude core.
package sgm_pkg;

    localparam int PIX_W      = 8;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int FRAC_BITS  = 4;

    localparam int COL_W = $clog2(MAX_WIDTH);      // line store address
    localparam int FW_W  = 12;                     // frame_width register
    localparam int FH_W  = 13;                     // frame_height register
    localparam int ROW_W = 13;                     // row position, up to height+1

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;
    localparam logic [FW_W-1:0] FW_RESET = 12'd640;
    localparam logic [FH_W-1:0] FH_RESET = 13'd480;

    localparam int GRAD_W = 12;                    // signed Sobel sum, |g| <= 1020
    localparam int SUM_W  = 21;                    // gx^2 + gy^2 <= 2080800
    localparam int ROOT_W = (SUM_W + 2 * FRAC_BITS + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int CNT_W  = $clog2(ROOT_W);
    localparam int MAG_W  = 15;
    localparam int LINE_W = 2 * PIX_W;             // {upper, middle} per column

    // [column left..right][row top..bottom]
    typedef logic [2:0][2:0][PIX_W-1:0] win_t;
    typedef logic signed [GRAD_W-1:0] grad_t;

    function automatic grad_t px(input logic [PIX_W-1:0] p);
        px = $signed({{(GRAD_W - PIX_W){1'b0}}, p});
    endfunction

    function automatic grad_t sobel_gx(input win_t w);
        sobel_gx = (px(w[2][0]) + (px(w[2][1]) <<< 1) + px(w[2][2]))
                 - (px(w[0][0]) + (px(w[0][1]) <<< 1) + px(w[0][2]));
    endfunction

    function automatic grad_t sobel_gy(input win_t w);
        sobel_gy = (px(w[0][0]) + (px(w[1][0]) <<< 1) + px(w[2][0]))
                 - (px(w[0][2]) + (px(w[1][2]) <<< 1) + px(w[2][2]));
    endfunction

endpackage

### rtl/sgm_if.sv
// Handshake channels of the Sobel gradient magnitude core.
interface sgm_pixel_if import sgm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;
    logic             pad;
    modport source (output valid, pixel_value, pad, input ready);
    modport sink   (input valid, pixel_value, pad, output ready);
endinterface

interface sgm_result_if import sgm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] magnitude;
    logic             last_of_frame;
    modport source (output valid, magnitude, last_of_frame, input ready);
    modport sink   (input valid, magnitude, last_of_frame, output ready);
endinterface

interface sgm_cfg_if import sgm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/sgm_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module sgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/sobel_gradient_magnitude_core.sv
// Streaming 3x3 Sobel gradient magnitude over a raster pixel stream.
//
// Channels: pixel (sink) takes one word per raster pixel, pixel_value plus a
// pad flag; result (source) gives one word per frame pixel, magnitude as
// unsigned fixed point with 4 fraction bits (floor of 16*sqrt(gx^2+gy^2)),
// and last_of_frame on the frame's final pixel. cfg (sink, always ready)
// writes frame_width (index 0) and frame_height (index 1); write only while
// the block is idle. Neighbors outside the frame count as zero.
// Results lag the input by one row plus one pixel: after each frame send
// frame_width+1 pad words; the last of them releases the flagged result.
// Steps: a word that yields no result is accepted, then goes through the
// line store read-modify-write. A word that yields a result goes on to a
// squaring state, the bit-serial square root (one result bit per cycle),
// and a final state that loads the output register; pixel is not ready meanwhile.
// The output register parts the two sides: pixel stays ready while a result
// waits; if the receiver stalls, the next result waits in the final state.
// Reset: registers to 640 x 480, position to row 0 column 0, window cleared.
// The line store is not cleared; rows outside the frame read as zero.
module sobel_gradient_magnitude_core import sgm_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    sgm_pixel_if.sink       pixel,
    sgm_result_if.source    result,
    sgm_cfg_if.sink         cfg
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_SQUARE = 3'd2;
    localparam logic [2:0] S_ROOT   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    // control state
    logic [2:0]       state_reg, state_next;
    logic [FW_W-1:0]  fw_reg, fw_next;
    logic [FH_W-1:0]  fh_reg, fh_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    win_t             win_reg, win_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    // payload
    logic [PIX_W-1:0]  v_reg, v_next;
    logic              last_reg, last_next;
    grad_t             gx_reg, gx_next, gy_reg, gy_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic              flag_reg, flag_next;

    // effective frame size (out-of-range values clamped)
    logic [FW_W-1:0]  w_eff;
    logic [FH_W-1:0]  h_eff;
    logic [ROW_W:0]   h_plus1, h_plus2, row_ext;
    logic             pos_wrap, accept;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;

    // line store: one entry per column, {upper, middle}
    logic              ram_wr_en;
    logic [LINE_W-1:0] ram_wr_data, ram_rd_data;
    logic [PIX_W-1:0]  up_px, mid_px;
    logic              emit, col_zero;
    logic [FW_W-1:0]   col_inc;
    win_t              mag_win;

    // square root step
    logic [ROOT_W+2:0]             rem_sh, trial, diff;
    logic signed [2*GRAD_W-1:0]    sq_sum;

    always_comb
    begin
        w_eff = fw_reg;
        if (fw_reg == '0)
        begin
            w_eff = FW_W'(1);
        end
        else if (fw_reg > FW_W'(MAX_WIDTH))
        begin
            w_eff = FW_W'(MAX_WIDTH);
        end
        h_eff = fh_reg;
        if (fh_reg == '0)
        begin
            h_eff = FH_W'(1);
        end
        else if (fh_reg > FH_W'(MAX_HEIGHT))
        begin
            h_eff = FH_W'(MAX_HEIGHT);
        end
    end

    assign h_plus1 = {1'b0, h_eff} + (ROW_W + 1)'(1);
    assign h_plus2 = {1'b0, h_eff} + (ROW_W + 1)'(2);
    assign row_ext = {1'b0, row_reg};

    // restart at the frame origin if the stored position no longer fits
    assign pos_wrap = ({1'b0, col_reg} >= w_eff) || (row_ext > h_plus1);
    assign cur_col  = pos_wrap ? '0 : col_reg;
    assign cur_row  = pos_wrap ? '0 : row_reg;

    assign pixel.ready = (state_reg == S_IDLE);
    assign accept      = pixel.valid && pixel.ready;
    assign cfg.ready   = 1'b1;

    sgm_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (col_reg),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (cur_col),
        .rd_data (ram_rd_data)
    );

    // read-modify-write: middle moves up, new pixel becomes middle
    assign ram_wr_en   = (state_reg == S_READ);
    assign ram_wr_data = {ram_rd_data[PIX_W-1:0], v_reg};

    assign up_px  = (row_reg >= ROW_W'(2) && row_ext < h_plus2)
                    ? ram_rd_data[LINE_W-1:PIX_W] : '0;
    assign mid_px = (row_reg >= ROW_W'(1) && row_ext < h_plus1)
                    ? ram_rd_data[PIX_W-1:0] : '0;

    assign col_zero = (col_reg == '0);
    assign col_inc  = {1'b0, col_reg} + FW_W'(1);
    assign emit     = col_zero ? (row_reg >= ROW_W'(2)) : (row_reg >= ROW_W'(1));

    // window the magnitude is taken over; at column 0 it closes the previous
    // row with a zero right column
    always_comb
    begin
        mag_win[0] = win_reg[1];
        mag_win[1] = win_reg[2];
        if (col_zero)
        begin
            mag_win[2] = '0;
        end
        else
        begin
            mag_win[2][0] = up_px;
            mag_win[2][1] = mid_px;
            mag_win[2][2] = v_reg;
        end
    end

    assign sq_sum = gx_reg * gx_reg + gy_reg * gy_reg;

    // one result bit per step
    assign rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign diff   = rem_sh - trial;

    always_comb
    begin
        state_next     = state_reg;
        fw_next        = fw_reg;
        fh_next        = fh_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        win_next       = win_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        v_next         = v_reg;
        last_next      = last_reg;
        gx_next        = gx_reg;
        gy_next        = gy_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        mag_next       = mag_reg;
        flag_next      = flag_reg;

        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_FRAME_WIDTH:  fw_next = cfg.data[FW_W-1:0];
                CFG_FRAME_HEIGHT: fh_next = cfg.data[FH_W-1:0];
            endcase
        end

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    col_next   = cur_col;
                    row_next   = cur_row;
                    v_next     = (pixel.pad || {1'b0, cur_row} >= {1'b0, h_eff})
                                 ? '0 : pixel.pixel_value;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                gx_next   = sobel_gx(mag_win);
                gy_next   = sobel_gy(mag_win);
                last_next = col_zero && (row_ext == h_plus1);
                if (col_zero)
                begin
                    win_next       = '0;
                    win_next[2][0] = up_px;
                    win_next[2][1] = mid_px;
                    win_next[2][2] = v_reg;
                end
                else
                begin
                    win_next = mag_win;
                end
                // advance the position
                if (row_ext == h_plus1)
                begin
                    col_next = '0;
                    row_next = '0;
                end
                else if (col_inc >= w_eff)
                begin
                    col_next = '0;
                    row_next = row_reg + ROW_W'(1);
                end
                else
                begin
                    col_next = col_inc[COL_W-1:0];
                end
                state_next = emit ? S_SQUARE : S_IDLE;
            end
            S_SQUARE:
            begin
                rad_next   = RAD_W'({sq_sum[SUM_W-1:0], {(2 * FRAC_BITS){1'b0}}});
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = '0;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                rad_next = rad_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_next  = diff[ROOT_W:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh[ROOT_W:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    mag_next       = MAG_W'(root_reg);
                    flag_next      = last_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fw_reg        <= FW_RESET;
            fh_reg        <= FH_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            win_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fw_reg        <= fw_next;
            fh_reg        <= fh_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            win_reg       <= win_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        last_reg <= last_next;
        gx_reg   <= gx_next;
        gy_reg   <= gy_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        mag_reg  <= mag_next;
        flag_reg <= flag_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.magnitude     = mag_reg;
    assign result.last_of_frame = flag_reg;

    // an accepted word always goes straight to the line store update
    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_READ)
        else $error("accepted word did not reach the line store update");

    // the root unit runs exactly ROOT_W steps
    a_root_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SQUARE |=> ##ROOT_W state_reg == S_DONE)
        else $error("square root did not finish in ROOT_W steps");

    // the flagged result returns the position to the frame origin
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ && emit && col_zero && row_ext == h_plus1)
        |=> (col_reg == '0 && row_reg == '0))
        else $error("position not reset at frame end");

endmodule
